[hw/rtl/linear_universal_hash_mod_prime_assert.svh]
// Assertion macros for the linear hash block.
// Each macro names the clock and reset of the block that uses it.
`ifndef LINEAR_UNIVERSAL_HASH_MOD_PRIME_ASSERT_SVH
`define LINEAR_UNIVERSAL_HASH_MOD_PRIME_ASSERT_SVH
`ifndef SYNTHESIS
`define LUH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("linear hash assertion failed");
`define LUH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("linear hash assertion failed");
`else
`define LUH_ASSERT_IMP(label, ante, cons)
`define LUH_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/luh_pkg.sv]
`timescale 1ns / 1ps
package luh_pkg;
    localparam int unsigned TBL_DEPTH = 1024;
    localparam int unsigned TBL_AW    = 10;
    localparam int unsigned COEF_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PROD_W    = COEF_W + BYTE_W;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned HASH_W    = 32;

    // 2^32 - 5, and 2^32 mod that prime
    localparam logic [HASH_W-1:0] HASH_PRIME = 32'hFFFF_FFFB;
    localparam logic [2:0]        FOLD_K     = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [TBL_AW-1:0] tbl_addr_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [HASH_W-1:0] hash_t;
endpackage

[hw/rtl/linear_universal_hash_mod_prime.sv]
`timescale 1ns / 1ps
// Keyed linear hash of byte strings, reduced modulo 2^32 - 5.
// Input channel (s_valid/s_ready): cmd 0 writes coeff_value into the coefficient
// table at coeff_index; cmd 1 delivers a message byte, last marks the final one.
// Result channel (m_valid/m_ready): one transfer per final byte, carrying
// hash_value and valid_res (0, with hash 0, when the message exceeded MAX_LEN).
// cfg_we/cfg_wdata load the 64-bit base constant; write it only while idle.
// Throughput: one item per cycle. The single-port coefficient memory takes one
// read or one write per cycle and the 64-bit accumulator closes its loop in its
// own register. A result's final byte passes the memory read, multiply,
// accumulate, two modular folds and a compare-subtract into the output register.
// A waiting result sits in the output register while later items keep flowing;
// s_ready drops only when a second result reaches the last stage while the
// first is still untaken.
// Reset clears the byte position, the too-long flag, the pipeline valids,
// the output valid and the base constant. The coefficient table is not
// cleared: an entry must be written before a message reads it.
`include "linear_universal_hash_mod_prime_assert.svh"
module linear_universal_hash_mod_prime #(
    parameter int unsigned MAX_LEN = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  luh_pkg::acc_t         cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  luh_pkg::tbl_addr_t    s_coeff_index,
    input  luh_pkg::coef_t        s_coeff_value,
    input  luh_pkg::byte_t        s_data_byte,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output luh_pkg::hash_t        m_hash_value,
    output logic                  m_valid_res
);
    import luh_pkg::*;

    localparam int unsigned PW = $clog2(MAX_LEN + 1);
    // wide enough to hold the table depth itself for the compare
    localparam int unsigned XW = (PW > TBL_AW) ? PW : TBL_AW + 1;

    logic [PW-1:0] pos_reg, pos_next;
    logic          tl_reg, tl_next;
    acc_t          base_reg;

    coef_t         mem [TBL_DEPTH];
    coef_t         rd_reg;

    logic          en, acc_byte;
    logic [XW-1:0] pos_ext;
    tbl_addr_t     rd_addr;
    logic          in_range, in_table;

    logic          s1_valid_reg, s1_first_reg, s1_add_reg, s1_last_reg, s1_err_reg;
    byte_t         s1_byte_reg;
    logic          s2_valid_reg, s2_first_reg, s2_last_reg, s2_err_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    acc_t          acc_reg, acc_next;
    logic          s3_valid_reg, s3_err_reg;
    logic [HASH_W+2:0] s4_fold_reg;
    logic          s4_valid_reg, s4_err_reg;
    logic [HASH_W:0]   s5_fold_reg, s5_sub;
    logic          s5_valid_reg, s5_err_reg;
    hash_t         red;

    logic          out_valid_reg, out_valid_next;
    hash_t         out_hash_reg;
    logic          out_res_reg;

    // stall only when a result must enter a full, untaken output register
    assign en       = !(s5_valid_reg && out_valid_reg && !m_ready);
    assign s_ready  = en;
    assign acc_byte = s_valid && en && (s_cmd == CMD_BYTE);

    assign pos_ext  = XW'(pos_reg);
    assign rd_addr  = pos_ext[TBL_AW-1:0];
    assign in_range = pos_ext < XW'(MAX_LEN);
    assign in_table = pos_ext < XW'(TBL_DEPTH);

    always_comb begin
        pos_next = pos_reg;
        tl_next  = tl_reg;
        if (acc_byte) begin
            if (s_last) begin
                pos_next = '0;
                tl_next  = 1'b0;
            end else if (in_range) begin
                pos_next = pos_reg + PW'(1);
            end else begin
                tl_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            tl_reg   <= 1'b0;
            base_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            tl_reg  <= tl_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // coefficient table: one write or one read per transfer
    always_ff @(posedge aclk) begin
        if (s_valid && en && (s_cmd == CMD_WRITE)) begin
            mem[s_coeff_index] <= s_coeff_value;
        end
        if (acc_byte) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign acc_next = (s2_first_reg ? base_reg : acc_reg) + ACC_W'(s2_prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= acc_byte;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_byte_reg  <= s_data_byte;
            s1_first_reg <= (pos_reg == '0);
            s1_add_reg   <= in_range && in_table;
            s1_last_reg  <= s_last;
            s1_err_reg   <= tl_reg || !in_range;

            s2_prod_reg  <= s1_add_reg ? (PROD_W'(rd_reg) * PROD_W'(s1_byte_reg)) : '0;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_err_reg   <= s1_err_reg;

            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            s3_err_reg <= s2_err_reg;

            // fold the high word: 2^32 is congruent to 5
            s4_fold_reg <= (HASH_W+3)'(acc_reg[ACC_W-1:HASH_W]) * (HASH_W+3)'(FOLD_K)
                         + (HASH_W+3)'(acc_reg[HASH_W-1:0]);
            s4_err_reg  <= s3_err_reg;

            s5_fold_reg <= (HASH_W+1)'(s4_fold_reg[HASH_W+2:HASH_W]) * (HASH_W+1)'(FOLD_K)
                         + (HASH_W+1)'(s4_fold_reg[HASH_W-1:0]);
            s5_err_reg  <= s4_err_reg;
        end
    end

    // value stays below twice the prime, so one subtract completes the reduction
    assign s5_sub = s5_fold_reg - (HASH_W+1)'(HASH_PRIME);
    assign red    = (s5_fold_reg >= (HASH_W+1)'(HASH_PRIME)) ? s5_sub[HASH_W-1:0]
                                                            : s5_fold_reg[HASH_W-1:0];

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s5_valid_reg && en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_valid_reg && en) begin
            out_hash_reg <= s5_err_reg ? '0 : red;
            out_res_reg  <= !s5_err_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;
    assign m_valid_res  = out_res_reg;

    `LUH_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= PW'(MAX_LEN))
    `LUH_ASSERT_IMP(a_flag_at_limit, tl_reg, pos_reg == PW'(MAX_LEN))
    `LUH_ASSERT_NXT(a_last_clears, acc_byte && s_last, (pos_reg == '0) && !tl_reg)
    `LUH_ASSERT_IMP(a_hash_below_prime, m_valid, m_hash_value < HASH_PRIME)
    `LUH_ASSERT_IMP(a_error_zero, m_valid && !m_valid_res, m_hash_value == '0)
endmodule

[bench/tb_linear_universal_hash_mod_prime.sv]
`timescale 1ns / 1ps
module tb_linear_universal_hash_mod_prime;
    import luh_pkg::*;

    localparam int unsigned MSG_MAX    = 1024;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          HOLD_LEN   = 300;
    localparam coef_t       COEF_TOP   = 32'hFFFF_FFFA;

    typedef struct {
        logic      cmd;
        tbl_addr_t coeff_index;
        coef_t     coeff_value;
        byte_t     data_byte;
        logic      last;
    } hash_item_t;

    typedef struct {
        hash_t hash_value;
        logic  valid_res;
    } digest_t;

    logic      aclk;
    logic      aresetn       = 1'b0;
    logic      cfg_we        = 1'b0;
    acc_t      cfg_wdata     = '0;
    logic      s_valid       = 1'b0;
    logic      s_ready;
    logic      s_cmd         = CMD_WRITE;
    tbl_addr_t s_coeff_index = '0;
    coef_t     s_coeff_value = '0;
    byte_t     s_data_byte   = '0;
    logic      s_last        = 1'b0;
    logic      m_valid;
    logic      m_ready       = 1'b0;
    hash_t     m_hash_value;
    logic      m_valid_res;

    logic sender_gaps   = 1'b1;
    logic rx_free       = 1'b0;
    logic long_hold_req = 1'b0;

    hash_item_t items_pending[$];
    digest_t    digests_due[$];
    int         n_pushed   = 0;
    int         n_sent     = 0;
    int         fail_count = 0;

    // predictor state
    acc_t        base_key = '0;
    coef_t       coef_mem [TBL_DEPTH];
    acc_t        acc_model = '0;
    int unsigned msg_pos   = 0;
    bit          overrun   = 1'b0;

    // generator view of which coefficient entries hold a value
    bit gen_written [TBL_DEPTH];

    hash_item_t next_item;
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         hold_left   = 0;
    bit         hold_done   = 1'b0;
    int         rx_mode     = 0;
    int         mode_left   = 0;
    logic [7:0] stall_pat   = 8'h01;
    int         idle_cycles = 0;
    digest_t    got_due;

    linear_universal_hash_mod_prime #(
        .MAX_LEN(MSG_MAX)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_coeff_index (s_coeff_index),
        .s_coeff_value (s_coeff_value),
        .s_data_byte   (s_data_byte),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_value  (m_hash_value),
        .m_valid_res   (m_valid_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void hash_predict(input logic cmd, input tbl_addr_t idx,
                                         input coef_t val, input byte_t data,
                                         input logic fin);
        digest_t d;
        if (cmd == CMD_WRITE) begin
            coef_mem[idx] = val;
            return;
        end
        if (msg_pos == 0)
            acc_model = base_key;
        if (msg_pos < MSG_MAX) begin
            if (msg_pos < TBL_DEPTH)
                acc_model = acc_model + acc_t'(coef_mem[msg_pos]) * acc_t'(data);
            msg_pos++;
        end else begin
            overrun = 1'b1;
        end
        if (fin) begin
            if (overrun) begin
                d.hash_value = '0;
                d.valid_res  = 1'b0;
            end else begin
                d.hash_value = hash_t'(acc_model % acc_t'(HASH_PRIME));
                d.valid_res  = 1'b1;
            end
            digests_due.push_back(d);
            msg_pos = 0;
            overrun = 1'b0;
        end
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return COEF_TOP;
            default: return coef_t'($urandom_range(COEF_TOP, 0));
        endcase
    endfunction

    function automatic byte_t rand_byte();
        case ($urandom_range(7, 0))
            0: return 8'h00;
            1: return 8'hFF;
            default: return byte_t'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic void add_item(input logic cmd, input tbl_addr_t idx, input coef_t val,
                                     input byte_t data, input logic fin);
        hash_item_t it;
        it.cmd         = cmd;
        it.coeff_index = idx;
        it.coeff_value = val;
        it.data_byte   = data;
        it.last        = fin;
        items_pending.push_back(it);
        n_pushed++;
    endfunction

    function automatic void add_write(input tbl_addr_t idx, input coef_t val);
        add_item(CMD_WRITE, idx, val, byte_t'($urandom), logic'($urandom_range(1, 0)));
        gen_written[idx] = 1'b1;
    endfunction

    // index and value ride along as noise on byte items
    function automatic void add_byte(input byte_t data, input logic fin);
        add_item(CMD_BYTE, tbl_addr_t'($urandom), coef_t'($urandom), data, fin);
    endfunction

    function automatic void add_message(input int len, input bit sat, input bit mix);
        for (int p = 0; p < len; p++) begin
            if (mix && $urandom_range(11, 0) == 0)
                add_write(tbl_addr_t'($urandom_range(TBL_DEPTH - 1, 0)), rand_coef());
            // fill an entry just ahead of the byte that reads it
            if (p < TBL_DEPTH && !gen_written[p])
                add_write(tbl_addr_t'(p), rand_coef());
            add_byte(sat ? 8'hFF : rand_byte(), p == len - 1);
        end
    endfunction

    function automatic void random_phase(input int n_items);
        int start;
        int pick;
        start = n_pushed;
        while (n_pushed - start < n_items) begin
            pick = $urandom_range(19, 0);
            if (pick < 3)
                add_write(tbl_addr_t'($urandom_range(TBL_DEPTH - 1, 0)), rand_coef());
            else if (pick < 15)
                add_message($urandom_range(6, 1), 1'b0, 1'b1);
            else if (pick < 19)
                add_message($urandom_range(24, 7), 1'b0, 1'b1);
            else
                add_message($urandom_range(100, 25), 1'b0, 1'b1);
        end
    endfunction

    // wait for every transfer and every hash, then let the pipeline drain
    task automatic settle();
        while (n_sent != n_pushed || digests_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_base(input acc_t v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        base_key = v;
    endtask

    // input channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                hash_predict(s_cmd, s_coeff_index, s_coeff_value, s_data_byte, s_last);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (sender_gaps && gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (items_pending.size() > 0) begin
                    next_item = items_pending.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= next_item.cmd;
                    s_coeff_index <= next_item.coeff_index;
                    s_coeff_value <= next_item.coeff_value;
                    s_data_byte   <= next_item.data_byte;
                    s_last        <= next_item.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (digests_due.size() == 0) begin
                    $error("result transfer with no hash outstanding");
                    fail_count++;
                end else begin
                    got_due = digests_due.pop_front();
                    if (m_hash_value !== got_due.hash_value) begin
                        $error("hash_value: expected %0d, got %0d",
                               got_due.hash_value, m_hash_value);
                        fail_count++;
                    end
                    if (m_valid_res !== got_due.valid_res) begin
                        $error("valid_res: expected %0d, got %0d",
                               got_due.valid_res, m_valid_res);
                        fail_count++;
                    end
                end
            end
            if (long_hold_req && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(3, 0);
                mode_left = $urandom_range(60, 5);
                stall_pat = 8'($urandom) | 8'h01;
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_free) begin
                m_ready <= 1'b1;
            end else begin
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= logic'($urandom_range(1, 0));
                    2: m_ready <= ($urandom_range(7, 0) == 0);
                    default: begin
                        m_ready   <= stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[7:1]};
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        set_base('0);
        add_write(10'd0, COEF_TOP);
        add_write(10'd1, '0);
        add_write(10'd2, 32'd1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h01, 1'b1);
        // last on a write item is ignored
        add_item(CMD_WRITE, 10'h3FF, COEF_TOP, 8'hFF, 1'b1);
        gen_written[10'h3FF] = 1'b1;
        // rewrite an entry mid-message, ahead of the byte that reads it
        add_byte(8'h80, 1'b0);
        add_write(10'd1, COEF_TOP);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b0);
        add_write(10'd3, COEF_TOP);
        add_byte(8'hFF, 1'b1);

        // accumulator wraps past 2^64
        set_base('1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        add_message(4, 1'b1, 1'b0);

        // hold the result side off while single-byte messages keep coming
        settle();
        sender_gaps   <= 1'b0;
        long_hold_req <= 1'b1;
        for (int k = 0; k < 40; k++)
            add_message(1, 1'b0, 1'b0);
        settle();
        sender_gaps <= 1'b1;

        set_base({32'($urandom), 32'($urandom)});
        random_phase(115);

        set_base('0);
        sender_gaps <= 1'b0;
        rx_free     <= 1'b1;
        random_phase(115);

        set_base({32'($urandom), 32'($urandom)});
        sender_gaps <= 1'b1;
        rx_free     <= 1'b0;
        random_phase(110);

        // full table, then messages at and just beyond the length limit
        set_base('1);
        for (int p = 0; p < TBL_DEPTH; p++)
            if (!gen_written[p])
                add_write(tbl_addr_t'(p), ($urandom_range(1, 0) == 0) ? COEF_TOP : rand_coef());
        add_message(MSG_MAX, 1'b1, 1'b0);
        add_message(MSG_MAX + 1, 1'b1, 1'b0);

        set_base({1'b1, 31'($urandom), 32'($urandom)});
        random_phase(110);

        settle();
        repeat (12) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
